// File: rtl/core/page_run_allocator_assert.svh
// Assertion helpers used by the page run allocator RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PAGE_RUN_ALLOCATOR_ASSERT_SVH
`define PAGE_RUN_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PRA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page_run_allocator: same-cycle check failed");

// next-cycle implication
`define PRA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page_run_allocator: next-cycle check failed");

`endif

// File: rtl/core/pra_pkg.sv
`default_nettype none

package pra_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;

	localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

	localparam logic [16:0] PAGES_RESET = 17'd65536;
	localparam logic [15:0] FLOOR_RESET = 16'd256;

	// register index, taken from paddr[2]
	localparam logic REG_PAGES = 1'b0;
	localparam logic REG_FLOOR = 1'b1;

	typedef enum logic [1:0] {
		OP_MARK   = 2'd0,
		OP_FREE   = 2'd1,
		OP_SEARCH = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] first_page;
		logic [16:0] end_page;
		logic [16:0] run_length;
	} req_t;

	typedef struct packed {
		logic [15:0] start_page;
		logic        found;
	} rsp_t;

	typedef struct packed {
		logic [16:0] pages_in_use;
		logic [15:0] search_floor;
	} cfg_t;

	// per-word controls for the bitmap word evaluator
	typedef struct packed {
		logic       first_word;
		logic       last_word;
		logic [4:0] lo_bit;
		logic [4:0] hi_bit;
		logic       win_on;
		logic [2:0] win_log;
		logic [3:0] win_extra;
		logic       carry_all;
		logic       carry_none;
		logic [4:0] carry_sh;
	} scan_ctl_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] range_mask;
		logic                 hit;
		logic [4:0]           hit_idx;
		logic                 all_free;
		logic [4:0]           lead_free;
	} scan_res_t;

	// index of the lowest set bit, 0 when none
	function automatic logic [4:0] low_index(input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] iso;
		logic [4:0]           idx;
		iso = v & (~v + 32'd1);
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (iso[i]) begin
				idx = idx | 5'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [2:0] floor_log2_6(input logic [5:0] k);
		logic [2:0] r;
		r = '0;
		for (int b = 0; b < 6; b++) begin
			if (k[b]) begin
				r = 3'(b);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/pra_ram.sv
`default_nettype none

module pra_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/pra_regs.sv
`default_nettype none

module pra_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pra_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [pra_pkg::PDATA_W-1:0]  pwdata,
	output logic      [pra_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	output pra_pkg::cfg_t                     cfg
);

	logic [16:0] pages_q;
	logic [15:0] floor_q;
	logic        wr;

	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q <= pra_pkg::PAGES_RESET;
			floor_q <= pra_pkg::FLOOR_RESET;
		end else if (wr) begin
			case (paddr[2])
				pra_pkg::REG_PAGES: begin
					pages_q <= pwdata[16:0];
				end
				pra_pkg::REG_FLOOR: begin
					floor_q <= pwdata[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pra_pkg::REG_PAGES: prdata = {15'd0, pages_q};
			pra_pkg::REG_FLOOR: prdata = {16'd0, floor_q};
			default:            prdata = '0;
		endcase
	end

	assign cfg.pages_in_use = pages_q;
	assign cfg.search_floor = floor_q;

endmodule

`default_nettype wire

// File: rtl/core/pra_scan.sv
`default_nettype none

// Evaluates one 32-page bitmap word: range mask, first completed free run,
// and the free run left open at the top of the word.
module pra_scan (
	input  wire logic [pra_pkg::WORD_BITS-1:0] data,
	input  wire pra_pkg::scan_ctl_t            ctl,
	output pra_pkg::scan_res_t                 res
);

	logic [pra_pkg::WORD_BITS-1:0] lo_m;
	logic [pra_pkg::WORD_BITS-1:0] hi_m;
	logic [pra_pkg::WORD_BITS-1:0] rng;
	logic [pra_pkg::WORD_BITS-1:0] fr;
	logic [pra_pkg::WORD_BITS-1:0] zr;
	logic [pra_pkg::WORD_BITS-1:0] zr_rev;
	logic [pra_pkg::WORD_BITS-1:0] lowz;
	logic [pra_pkg::WORD_BITS-1:0] pf;
	logic [pra_pkg::WORD_BITS-1:0] thr_m;
	logic [pra_pkg::WORD_BITS-1:0] wsel;
	logic [pra_pkg::WORD_BITS-1:0] win;
	logic [pra_pkg::WORD_BITS-1:0] hit_v;
	logic [pra_pkg::WORD_BITS-1:0] wpow [6];

	always_comb begin
		lo_m = ctl.first_word ? (pra_pkg::ALL_ONES << ctl.lo_bit) : pra_pkg::ALL_ONES;
		hi_m = ctl.last_word ? (pra_pkg::ALL_ONES >> (5'd31 - ctl.hi_bit))
			: pra_pkg::ALL_ONES;
		rng  = lo_m & hi_m;
		// pages outside the range count as used
		fr   = ~data & rng;
		zr   = ~fr;
		for (int i = 0; i < pra_pkg::WORD_BITS; i++) begin
			zr_rev[i] = zr[pra_pkg::WORD_BITS-1-i];
		end
		// free prefix: every bit below the lowest used page
		lowz = zr & (~zr + 32'd1);
		pf   = lowz - 32'd1;
		// prefix bits where the carried run plus the prefix reaches the length
		thr_m = ctl.carry_all ? pra_pkg::ALL_ONES
			: (ctl.carry_none ? '0 : (pra_pkg::ALL_ONES << ctl.carry_sh));
		// wpow[s] bit j: pages j-2^s+1 .. j all free inside this word
		wpow[0] = fr;
		for (int s = 0; s < 5; s++) begin
			wpow[s+1] = wpow[s] & (wpow[s] << (1 << s));
		end
		case (ctl.win_log)
			3'd0:    wsel = wpow[0];
			3'd1:    wsel = wpow[1];
			3'd2:    wsel = wpow[2];
			3'd3:    wsel = wpow[3];
			3'd4:    wsel = wpow[4];
			3'd5:    wsel = wpow[5];
			default: wsel = '0;
		endcase
		// two overlapping power-of-two windows cover the full run length
		win   = ctl.win_on ? (wsel & (wsel << ctl.win_extra)) : '0;
		hit_v = win | (pf & thr_m);

		res.range_mask = rng;
		res.hit        = |hit_v;
		res.hit_idx    = pra_pkg::low_index(hit_v);
		res.all_free   = ~|zr;
		res.lead_free  = pra_pkg::low_index(zr_rev);
	end

endmodule

`default_nettype wire

// File: rtl/core/pra_ctrl.sv
`default_nettype none

module pra_ctrl #(
	parameter int unsigned MAX_PAGES = 65536
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pra_pkg::cfg_t cfg,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire pra_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output pra_pkg::rsp_t      rsp_data
);

	localparam int unsigned PW    = $clog2(MAX_PAGES);
	localparam int unsigned AW    = PW - 5;
	localparam int unsigned DEPTH = (MAX_PAGES + 31) / 32;
	localparam int unsigned CW    = (PW + 1 > 17) ? PW + 1 : 17;

	localparam logic [CW-1:0] MAX_C     = CW'(MAX_PAGES);
	localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic          issue_q;
	logic          v_s1;
	logic          rsp_valid_q;
	logic [AW-1:0] clr_q;

	logic [1:0]    op_q;
	logic [AW-1:0] ra_q;
	logic [AW-1:0] wa_s1;
	logic [AW-1:0] fw_q;
	logic [AW-1:0] lw_q;
	logic [4:0]    lo_bit_q;
	logic [4:0]    hi_bit_q;
	logic [CW-1:0] cnt_q;
	logic [16:0]   want_q;
	logic          win_on_q;
	logic [2:0]    win_log_q;
	logic [3:0]    win_extra_q;
	logic          found_q;
	logic [PW-1:0] page_q;
	pra_pkg::rsp_t rsp_q;

	// request decode
	logic [CW-1:0] end_c;
	logic [CW-1:0] lim_c;
	logic [CW-1:0] lo_c;
	logic [CW-1:0] hi_c;
	logic [CW-1:0] last_c;
	logic          op_ok;
	logic          go_run;
	logic [16:0]   want_c;
	logic [2:0]    win_log_c;
	logic [3:0]    win_extra_c;

	// word pipeline
	logic                          is_search;
	logic                          word_end;
	logic                          finish;
	logic                          accept;
	logic                          load_rsp;
	logic [CW-1:0]                 wm1;
	logic [CW-1:0]                 diff;
	logic [CW-1:0]                 start_c;
	pra_pkg::scan_ctl_t            sctl;
	pra_pkg::scan_res_t            sres;
	logic [pra_pkg::WORD_BITS-1:0] rdata;
	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [pra_pkg::WORD_BITS-1:0] mem_wdata;

	always_comb begin
		end_c = CW'(req_data.end_page);
		lim_c = CW'(cfg.pages_in_use);
		if (req_data.opcode == pra_pkg::OP_SEARCH) begin
			lo_c = CW'(cfg.search_floor);
			hi_c = (lim_c < MAX_C) ? lim_c : MAX_C;
		end else begin
			lo_c = CW'(req_data.first_page);
			hi_c = (end_c < MAX_C) ? end_c : MAX_C;
		end
		last_c = hi_c - CW'(1);
		op_ok  = (req_data.opcode == pra_pkg::OP_MARK)
			|| (req_data.opcode == pra_pkg::OP_FREE)
			|| (req_data.opcode == pra_pkg::OP_SEARCH);
		go_run = op_ok && (lo_c < hi_c);

		want_c      = (req_data.run_length == 17'd0) ? 17'd1 : req_data.run_length;
		win_log_c   = pra_pkg::floor_log2_6(want_c[5:0]);
		win_extra_c = 4'(want_c[5:0] - (6'd1 << win_log_c));
	end

	assign accept    = (state_q == ST_IDLE) && req_valid;
	assign is_search = (op_q == pra_pkg::OP_SEARCH);
	assign word_end  = v_s1 && (wa_s1 == lw_q);
	assign finish    = (state_q == ST_RUN) && (word_end || (v_s1 && is_search && sres.hit));
	assign load_rsp  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// carried free count against the wanted length
	always_comb begin
		wm1  = CW'(want_q) - CW'(1);
		diff = wm1 - cnt_q;
		sctl.first_word = (wa_s1 == fw_q);
		sctl.last_word  = (wa_s1 == lw_q);
		sctl.lo_bit     = lo_bit_q;
		sctl.hi_bit     = hi_bit_q;
		sctl.win_on     = win_on_q;
		sctl.win_log    = win_log_q;
		sctl.win_extra  = win_extra_q;
		sctl.carry_all  = (cnt_q >= wm1);
		sctl.carry_none = |diff[CW-1:5];
		sctl.carry_sh   = diff[4:0];
	end

	pra_scan u_scan (
		.data (rdata),
		.ctl  (sctl),
		.res  (sres)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wa_s1;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
		end else if ((state_q == ST_RUN) && v_s1 && !is_search) begin
			mem_we    = 1'b1;
			mem_wdata = (op_q == pra_pkg::OP_MARK) ? (rdata | sres.range_mask)
				: (rdata & ~sres.range_mask);
		end
	end

	pra_ram #(
		.WIDTH (pra_pkg::WORD_BITS),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (ra_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			issue_q     <= 1'b0;
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= go_run ? ST_RUN : ST_DONE;
						issue_q <= go_run;
					end
				end
				ST_RUN: begin
					if (finish) begin
						state_q <= ST_DONE;
						issue_q <= 1'b0;
					end else if (issue_q && (ra_q == lw_q)) begin
						issue_q <= 1'b0;
					end
				end
				ST_DONE: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// drop reads still in flight once the request finishes
			v_s1 <= (state_q == ST_RUN) && issue_q && !finish;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign start_c = CW'(page_q) + CW'(1) - CW'(want_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= req_data.opcode;
			fw_q        <= lo_c[PW-1:5];
			lw_q        <= last_c[PW-1:5];
			ra_q        <= lo_c[PW-1:5];
			lo_bit_q    <= lo_c[4:0];
			hi_bit_q    <= last_c[4:0];
			cnt_q       <= '0;
			want_q      <= want_c;
			win_on_q    <= (want_c <= 17'd32);
			win_log_q   <= win_log_c;
			win_extra_q <= win_extra_c;
			found_q     <= 1'b0;
		end
		if (state_q == ST_RUN) begin
			wa_s1 <= ra_q;
			if (issue_q && (ra_q != lw_q)) begin
				ra_q <= ra_q + 1'b1;
			end
			if (v_s1 && is_search) begin
				if (sres.hit) begin
					found_q <= 1'b1;
					page_q  <= {wa_s1, sres.hit_idx};
				end else if (sres.all_free) begin
					cnt_q <= cnt_q + CW'(pra_pkg::WORD_BITS);
				end else begin
					cnt_q <= CW'(sres.lead_free);
				end
			end
		end
		if (load_rsp) begin
			rsp_q.found      <= found_q;
			rsp_q.start_page <= found_q ? start_c[15:0] : 16'd0;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`include "page_run_allocator_assert.svh"

	`PRA_ASSERT_IMP(a_we_state, mem_we, (state_q == ST_RUN) || (state_q == ST_CLEAR))
	`PRA_ASSERT_IMP(a_wr_range, mem_we && (state_q == ST_RUN), (wa_s1 >= fw_q) && (wa_s1 <= lw_q))
	`PRA_ASSERT_IMP(a_no_flight, state_q != ST_RUN, !v_s1 && !issue_q)
	`PRA_ASSERT_NEXT(a_done_rsp, load_rsp, rsp_valid && (state_q == ST_IDLE))

endmodule

`default_nettype wire

// File: rtl/core/page_run_allocator.sv
`default_nettype none

// First-fit page allocator over a used-page bitmap, 32 pages per memory word.
// Request channel (req_valid/req_ready/req_data): mark a page range used, free
// it, or search for the first run of run_length free pages from search_floor
// up to pages_in_use. Every request yields one response on rsp_valid/
// rsp_ready/rsp_data: start_page and found for a search, zeros otherwise.
// Configuration goes through the APB port: pages_in_use at 0x0,
// search_floor at 0x4; write only while no request is outstanding.
// Flow: an accepted request enters ST_RUN, where its words are handled in
// order, one word read-modify-written or scanned per cycle through the
// single bitmap memory; ST_DONE then loads the response register. A search
// stops at the first word holding a hit, and an empty range or unused
// opcode goes straight to ST_DONE without touching the bitmap.
// Requests are taken one at a time; the next one is accepted while the
// previous response still waits in its register. If the receiver stalls
// with a response pending, a finished request holds until that slot frees.
// Reset: the bitmap is cleared one word per cycle, every word of it, with
// req_ready low; APB writes are taken meanwhile.
module page_run_allocator #(
	parameter int unsigned MAX_PAGES = 65536
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pra_pkg::PADDR_W-1:0] paddr,
	input  wire logic [pra_pkg::PDATA_W-1:0] pwdata,
	output logic      [pra_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire pra_pkg::req_t               req_data,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output pra_pkg::rsp_t                    rsp_data
);

	pra_pkg::cfg_t cfg;

	pra_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pra_ctrl #(
		.MAX_PAGES (MAX_PAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

`default_nettype wire
